@@ rtl/mbb_pkg.sv @@
// ----------------------------------------------------------------------------
// mbb_pkg
// Shared types and constants for the mesh bounding box point search block.
// ----------------------------------------------------------------------------
package mbb_pkg;

    localparam int FifoDepth = 4;
    localparam int FifoPtrW  = $clog2(FifoDepth);
    localparam int FifoCntW  = $clog2(FifoDepth + 1);

    localparam int CoordW = 16;
    localparam int UidW   = 15;
    localparam int IdW    = 17;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 17;

    localparam logic [IdW-1:0] IdLimitReset = 17'd100000;

    typedef enum logic [CfgIdxW-1:0] {
        REG_QUERY_X  = 3'd0,
        REG_QUERY_Y  = 3'd1,
        REG_QUERY_Z  = 3'd2,
        REG_ID_LOW   = 3'd3,
        REG_ID_LIMIT = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [CoordW-1:0] query_x;
        logic [CoordW-1:0] query_y;
        logic [CoordW-1:0] query_z;
        logic [IdW-1:0]    id_low;
        logic [IdW-1:0]    id_limit;
    } t_cfg;

    // one closed mesh, as handed from the front to the back
    typedef struct packed {
        logic [UidW-1:0]           uid;
        logic [2:0][CoordW-1:0]    lo;
        logic [2:0][CoordW-1:0]    hi;
        logic                      model_end;
    } t_box;

endpackage

@@ rtl/mbb_front.sv @@
// ----------------------------------------------------------------------------
// mbb_front
// Accepts vertices, keeps the running per-axis box and pushes a closed box
// into the queue on the vertex that ends a mesh or a model.
// ----------------------------------------------------------------------------
module mbb_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [3*mbb_pkg::CoordW-1:0]  i_coords,
    input  logic [mbb_pkg::UidW-1:0]      i_uid,
    input  logic                          i_mesh_last,
    input  logic                          i_model_end,
    output logic                          o_push,
    output mbb_pkg::t_box                 o_box
);

    logic [2:0][mbb_pkg::CoordW-1:0] r_min;
    logic [2:0][mbb_pkg::CoordW-1:0] r_max;
    logic [2:0][mbb_pkg::CoordW-1:0] n_min;
    logic [2:0][mbb_pkg::CoordW-1:0] n_max;
    logic                            r_start;
    logic                            w_close;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_start) begin
                n_min[i] = i_coords[i*mbb_pkg::CoordW +: mbb_pkg::CoordW];
                n_max[i] = i_coords[i*mbb_pkg::CoordW +: mbb_pkg::CoordW];
            end else begin
                n_min[i] = r_min[i];
                n_max[i] = r_max[i];
                if ($signed(i_coords[i*mbb_pkg::CoordW +: mbb_pkg::CoordW])
                        < $signed(r_min[i])) begin
                    n_min[i] = i_coords[i*mbb_pkg::CoordW +: mbb_pkg::CoordW];
                end
                if ($signed(i_coords[i*mbb_pkg::CoordW +: mbb_pkg::CoordW])
                        > $signed(r_max[i])) begin
                    n_max[i] = i_coords[i*mbb_pkg::CoordW +: mbb_pkg::CoordW];
                end
            end
        end
    end

    assign w_close = i_mesh_last | i_model_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b1;
            r_min   <= '0;
            r_max   <= '0;
        end else if (i_accept) begin
            r_start <= w_close;
            r_min   <= n_min;
            r_max   <= n_max;
        end
    end

    assign o_push          = i_accept & w_close;
    assign o_box.uid       = i_uid;
    assign o_box.lo        = n_min;
    assign o_box.hi        = n_max;
    assign o_box.model_end = i_model_end;

endmodule

@@ rtl/mbb_fifo.sv @@
// ----------------------------------------------------------------------------
// mbb_fifo
// Short queue of closed boxes between the front and the back.
// ----------------------------------------------------------------------------
module mbb_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mbb_pkg::t_box  i_data,
    input  logic           i_pop,
    output mbb_pkg::t_box  o_data,
    output logic           o_full,
    output logic           o_empty
);

    mbb_pkg::t_box                   r_mem [mbb_pkg::FifoDepth];
    logic [mbb_pkg::FifoPtrW-1:0]    r_wr_ptr;
    logic [mbb_pkg::FifoPtrW-1:0]    r_rd_ptr;
    logic [mbb_pkg::FifoCntW-1:0]    r_count;

    assign o_full  = (r_count == mbb_pkg::FifoCntW'(mbb_pkg::FifoDepth));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/mbb_back.sv @@
// ----------------------------------------------------------------------------
// mbb_back
// Pops closed boxes, forms centers, runs the containment search and holds
// the result in the output register.
// ----------------------------------------------------------------------------
module mbb_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mbb_pkg::t_cfg              i_cfg,
    input  mbb_pkg::t_box              i_box,
    input  logic                       i_empty,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [175:0]               o_data,
    output logic                       o_model_done
);

    logic                              r_valid;
    logic [175:0]                      r_data;
    logic                              r_model_done;
    logic                              r_found;
    logic [mbb_pkg::UidW-1:0]          r_found_uid;
    logic                              n_found;
    logic [mbb_pkg::UidW-1:0]          n_found_uid;
    logic [2:0][mbb_pkg::CoordW-1:0]   w_center;
    logic                              w_match;
    logic                              w_in_range;
    logic [mbb_pkg::IdW-1:0]           w_uid_ext;
    logic [mbb_pkg::CoordW:0]          w_sum [3];
    logic [mbb_pkg::CoordW:0]          w_adj [3];

    assign o_pop = ~i_empty & (~r_valid | i_ready);

    // (lo+hi)/2 toward zero: add one to a negative sum before the shift
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sum[i] = {i_box.lo[i][mbb_pkg::CoordW-1], i_box.lo[i]}
                     + {i_box.hi[i][mbb_pkg::CoordW-1], i_box.hi[i]};
            w_adj[i] = w_sum[i] + {{mbb_pkg::CoordW{1'b0}}, w_sum[i][mbb_pkg::CoordW]};
            w_center[i] = w_adj[i][mbb_pkg::CoordW:1];
        end
    end

    assign w_uid_ext  = {2'b00, i_box.uid};
    assign w_in_range = (w_uid_ext >= i_cfg.id_low) && (w_uid_ext < i_cfg.id_limit);
    assign w_match    = w_in_range
                      && ($signed(i_box.lo[0]) < $signed(i_cfg.query_x))
                      && ($signed(i_cfg.query_x) < $signed(i_box.hi[0]))
                      && ($signed(i_box.lo[2]) < $signed(i_cfg.query_z))
                      && ($signed(i_cfg.query_z) < $signed(i_box.hi[2]));

    always_comb begin
        n_found     = r_found;
        n_found_uid = r_found_uid;
        if (!r_found && w_match) begin
            n_found     = 1'b1;
            n_found_uid = i_box.uid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_found     <= 1'b0;
            r_found_uid <= '0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                if (i_box.model_end) begin
                    r_found     <= 1'b0;
                    r_found_uid <= '0;
                end else begin
                    r_found     <= n_found;
                    r_found_uid <= n_found_uid;
                end
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= {2'b00,
                       (n_found ? n_found_uid : {mbb_pkg::UidW{1'b0}}),
                       w_center[2], w_center[1], w_center[0],
                       i_box.hi[2], i_box.hi[1], i_box.hi[0],
                       i_box.lo[2], i_box.lo[1], i_box.lo[0],
                       i_box.uid};
            r_model_done <= i_box.model_end;
        end
    end

    assign o_valid      = r_valid;
    assign o_data       = r_data;
    assign o_model_done = r_model_done;

    a_model_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_box.model_end) |=> (!r_found && r_found_uid == '0))
        else $error("search state not cleared after model end");

    a_found_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && r_found && !i_box.model_end) |=>
            (r_found && r_found_uid == $past(r_found_uid)))
        else $error("found mesh replaced within a model");

    a_no_pop_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |-> !o_pop)
        else $error("queue popped while output register held");

endmodule

@@ rtl/mesh_bounding_box_point_search.sv @@
// ----------------------------------------------------------------------------
// mesh_bounding_box_point_search
// Per-mesh bounding boxes with centers and a first-hit point containment
// search over a vertex stream.
// The box of a mesh-closing vertex is written into the queue when that vertex
// is accepted, and is valid on the output once popped into the output register.
// Throughput: one vertex per cycle; the 4-entry box queue absorbs output
// stalls, and s_axis_tready drops only when that queue is full.
// Reset (i_rst_n, synchronous, active low) clears the running box, search
// state, queue and output valid; registers return to their reset values.
// ----------------------------------------------------------------------------
module mesh_bounding_box_point_search (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // vertex_x[15:0], vertex_y[31:16], vertex_z[47:32], mesh_uid[62:48]
    input  logic [63:0]                     s_axis_tdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic                            s_axis_tlast,   // last vertex of a mesh
    input  logic                            s_axis_tuser,   // model_end
    // box_uid[14:0], min_x/y/z[62:15], max_x/y/z[110:63],
    // center_x/y/z[158:111], hit_uid[173:159]
    output logic [175:0]                    m_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic                            m_axis_tlast,   // model_done
    input  logic                            i_cfg_we,
    input  logic [mbb_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  logic [mbb_pkg::CfgDataW-1:0]    i_cfg_data
);

    mbb_pkg::t_cfg r_cfg;
    mbb_pkg::t_box w_push_box;
    mbb_pkg::t_box w_pop_box;
    logic          w_push;
    logic          w_pop;
    logic          w_full;
    logic          w_empty;
    logic          w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.query_x  <= '0;
            r_cfg.query_y  <= '0;
            r_cfg.query_z  <= '0;
            r_cfg.id_low   <= '0;
            r_cfg.id_limit <= mbb_pkg::IdLimitReset;
        end else if (i_cfg_we) begin
            case (mbb_pkg::t_reg_idx'(i_cfg_index))
                mbb_pkg::REG_QUERY_X:  r_cfg.query_x  <= i_cfg_data[15:0];
                mbb_pkg::REG_QUERY_Y:  r_cfg.query_y  <= i_cfg_data[15:0];
                mbb_pkg::REG_QUERY_Z:  r_cfg.query_z  <= i_cfg_data[15:0];
                mbb_pkg::REG_ID_LOW:   r_cfg.id_low   <= i_cfg_data;
                mbb_pkg::REG_ID_LIMIT: r_cfg.id_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = ~w_full;
    assign w_accept      = s_axis_tvalid & ~w_full;

    mbb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_coords    (s_axis_tdata[47:0]),
        .i_uid       (s_axis_tdata[62:48]),
        .i_mesh_last (s_axis_tlast),
        .i_model_end (s_axis_tuser),
        .o_push      (w_push),
        .o_box       (w_push_box)
    );

    mbb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_box),
        .i_pop   (w_pop),
        .o_data  (w_pop_box),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    mbb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_box        (w_pop_box),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_data       (m_axis_tdata),
        .o_model_done (m_axis_tlast)
    );

endmodule

@@ sim/tb_mesh_bounding_box_point_search.sv @@
// ----------------------------------------------------------------------------
// tb_mesh_bounding_box_point_search
// Streams vertices into the bounding box search block and checks every
// emitted box, center, hit id and model-done flag against a predictor kept
// in the bench. Covers directed corner meshes, then random models under
// several query and id-range settings, with random idling on both sides,
// one long output hold-off and pauses until the output side has drained.
// ----------------------------------------------------------------------------
module tb_mesh_bounding_box_point_search;

    localparam int SETTLE      = 8;    // cycles after the last vertex before a register write
    localparam int HOLD_CYCLES = 200;

    typedef enum logic [1:0] {
        OP_VERTEX,
        OP_CFG,
        OP_DRAIN,
        OP_HOLD
    } t_op;

    typedef struct packed {
        t_op                             op;
        logic [15:0]                     x;
        logic [15:0]                     y;
        logic [15:0]                     z;
        logic [mbb_pkg::UidW-1:0]        uid;
        logic                            closes_mesh;
        logic                            model_end;
        mbb_pkg::t_reg_idx               reg_idx;
        logic [mbb_pkg::CfgDataW-1:0]    value;
    } t_job;

    typedef struct packed {
        logic [mbb_pkg::UidW-1:0]   uid;
        logic [2:0][15:0]           lo;
        logic [2:0][15:0]           hi;
        logic [2:0][15:0]           ctr;
        logic [mbb_pkg::UidW-1:0]   hit;
        logic                       done;
    } t_box_exp;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic [63:0]                    s_tdata = '0;    // vertex_x, vertex_y, vertex_z, mesh_uid
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic                           s_tlast = 1'b0;  // last vertex of a mesh
    logic                           s_tuser = 1'b0;  // model_end
    logic [175:0]                   m_tdata;         // box_uid, min xyz, max xyz, center xyz, hit_uid
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic                           m_tlast;         // model_done
    logic                           cfg_we = 1'b0;
    logic [mbb_pkg::CfgIdxW-1:0]    cfg_index = '0;
    logic [mbb_pkg::CfgDataW-1:0]   cfg_data = '0;

    mesh_bounding_box_point_search u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_tdata),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tlast  (s_tlast),
        .s_axis_tuser  (s_tuser),
        .m_axis_tdata  (m_tdata),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tlast  (m_tlast),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    t_job       jobs[$];
    t_box_exp   boxes_due[$];

    // predictor state and register shadow
    logic signed [15:0]         box_lo [3] = '{0, 0, 0};
    logic signed [15:0]         box_hi [3] = '{0, 0, 0};
    logic                       box_open = 1'b1;
    logic [mbb_pkg::UidW-1:0]   match_uid = '0;
    logic                       match_seen = 1'b0;
    logic signed [15:0]         qry_x = '0;
    logic signed [15:0]         qry_y = '0;
    logic signed [15:0]         qry_z = '0;
    logic [mbb_pkg::IdW-1:0]    rng_lo = '0;
    logic [mbb_pkg::IdW-1:0]    rng_hi = mbb_pkg::IdLimitReset;

    // generator view of the settings, used to aim vertices and ids
    int gen_q [3] = '{0, 0, 0};
    int gen_lo = 0;
    int gen_lim = int'(mbb_pkg::IdLimitReset);

    int  faults = 0;
    int  n_queued = 0;
    int  n_taken = 0;
    int  n_writes = 0;
    int  n_boxes = 0;
    int  n_hits = 0;
    int  n_models = 0;
    int  quiet = 0;
    int  hold_left = 0;
    logic hold_kick = 1'b0;
    t_job cur_vertex;

    wire steady = (n_taken >= 300) && (n_taken < 420);

    task automatic fold_vertex(input t_job v);
        logic signed [15:0] coord [3];
        t_box_exp e;
        int sum;
        coord[0] = v.x;
        coord[1] = v.y;
        coord[2] = v.z;
        for (int i = 0; i < 3; i++) begin
            if (box_open) begin
                box_lo[i] = coord[i];
                box_hi[i] = coord[i];
            end else begin
                if (coord[i] < box_lo[i]) box_lo[i] = coord[i];
                if (coord[i] > box_hi[i]) box_hi[i] = coord[i];
            end
        end
        box_open = 1'b0;
        if (v.closes_mesh || v.model_end) begin
            // strict containment in X and Z, first match of the model wins
            if (!match_seen && {2'b00, v.uid} >= rng_lo && {2'b00, v.uid} < rng_hi &&
                box_lo[0] < qry_x && qry_x < box_hi[0] &&
                box_lo[2] < qry_z && qry_z < box_hi[2]) begin
                match_seen = 1'b1;
                match_uid = v.uid;
            end
            e.uid = v.uid;
            for (int i = 0; i < 3; i++) begin
                e.lo[i] = box_lo[i];
                e.hi[i] = box_hi[i];
                sum = box_lo[i];
                sum = sum + box_hi[i];
                sum = sum / 2;
                e.ctr[i] = sum[15:0];
            end
            e.hit = match_seen ? match_uid : '0;
            e.done = v.model_end;
            boxes_due.push_back(e);
            box_open = 1'b1;
            if (v.model_end) begin
                match_seen = 1'b0;
                match_uid = '0;
            end
        end
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            faults++;
            if (faults <= 10)
                $display("mismatch on %s: expected %0d, got %0d (box %0d)",
                         what, want, got, n_boxes);
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: vertices, register writes, drain pauses and hold-off kicks
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_job job;
        logic fire, offer, we, kick, drained;
        if (!i_rst_n) begin
            s_valid   <= 1'b0;
            cfg_we    <= 1'b0;
            hold_kick <= 1'b0;
            quiet     <= 0;
        end else begin
            fire = s_valid && s_ready;
            if (fire) begin
                fold_vertex(cur_vertex);
                n_taken <= n_taken + 1;
            end
            quiet <= fire ? 0 : (quiet < 1000 ? quiet + 1 : quiet);
            offer = s_valid && !fire;
            we = 1'b0;
            kick = 1'b0;
            if (!offer && jobs.size() != 0) begin
                job = jobs[0];
                drained = !fire && quiet >= SETTLE && boxes_due.size() == 0;
                case (job.op)
                    OP_VERTEX: begin
                        if (steady || $urandom_range(99) >= 22) begin
                            void'(jobs.pop_front());
                            cur_vertex = job;
                            offer = 1'b1;
                            s_tdata <= {1'b0, job.uid, job.z, job.y, job.x};
                            s_tlast <= job.closes_mesh;
                            s_tuser <= job.model_end;
                        end
                    end
                    OP_CFG: begin
                        if (drained) begin
                            void'(jobs.pop_front());
                            we = 1'b1;
                            cfg_index <= job.reg_idx;
                            cfg_data  <= job.value;
                            n_writes++;
                            case (job.reg_idx)
                                mbb_pkg::REG_QUERY_X:  qry_x = job.value[15:0];
                                mbb_pkg::REG_QUERY_Y:  qry_y = job.value[15:0];
                                mbb_pkg::REG_QUERY_Z:  qry_z = job.value[15:0];
                                mbb_pkg::REG_ID_LOW:   rng_lo = job.value;
                                mbb_pkg::REG_ID_LIMIT: rng_hi = job.value;
                                default: ;
                            endcase
                        end
                    end
                    OP_DRAIN: begin
                        if (drained) void'(jobs.pop_front());
                    end
                    OP_HOLD: begin
                        void'(jobs.pop_front());
                        kick = 1'b1;
                    end
                    default: void'(jobs.pop_front());
                endcase
            end
            s_valid   <= offer;
            cfg_we    <= we;
            hold_kick <= kick;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            hold_left <= 0;
        else if (hold_kick)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // ------------------------------------------------------------------------
    // monitor: result side ready and box checks
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_box_exp want, got;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got.uid = m_tdata[14:0];
                for (int i = 0; i < 3; i++) begin
                    got.lo[i]  = m_tdata[15 + 16 * i +: 16];
                    got.hi[i]  = m_tdata[63 + 16 * i +: 16];
                    got.ctr[i] = m_tdata[111 + 16 * i +: 16];
                end
                got.hit  = m_tdata[173:159];
                got.done = m_tlast;
                if (boxes_due.size() == 0) begin
                    faults++;
                    if (faults <= 10)
                        $display("unexpected box for mesh %0d with nothing pending", got.uid);
                end else begin
                    want = boxes_due.pop_front();
                    check_field("box_uid", want.uid, got.uid);
                    for (int i = 0; i < 3; i++) begin
                        check_field($sformatf("min[%0d]", i), $signed(want.lo[i]),
                                    $signed(got.lo[i]));
                        check_field($sformatf("max[%0d]", i), $signed(want.hi[i]),
                                    $signed(got.hi[i]));
                        check_field($sformatf("center[%0d]", i), $signed(want.ctr[i]),
                                    $signed(got.ctr[i]));
                    end
                    check_field("hit_uid", want.hit, got.hit);
                    check_field("model_done", want.done, got.done);
                end
                n_boxes++;
                if (got.hit != 0) n_hits++;
                if (got.done) n_models++;
            end
            m_ready <= (hold_left == 0) && (steady || $urandom_range(99) >= 22);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic push_vertex(input int x, input int y, input int z, input int uid,
                               input bit me, input bit mo);
        t_job j;
        j = '0;
        j.op = OP_VERTEX;
        j.x = x[15:0];
        j.y = y[15:0];
        j.z = z[15:0];
        j.uid = uid[mbb_pkg::UidW-1:0];
        j.closes_mesh = me;
        j.model_end = mo;
        jobs.push_back(j);
        n_queued++;
    endtask

    task automatic set_phase(input int qx, input int qy, input int qz,
                             input int lo, input int lim);
        t_job j;
        int vals [5];
        vals = '{qx, qy, qz, lo, lim};
        j = '0;
        j.op = OP_CFG;
        for (int r = 0; r < 5; r++) begin
            j.reg_idx = mbb_pkg::t_reg_idx'(r);
            j.value = vals[r][mbb_pkg::CfgDataW-1:0];
            jobs.push_back(j);
        end
        gen_q = '{qx, qy, qz};
        gen_lo = lo;
        gen_lim = lim;
    endtask

    task automatic push_op(input t_op op);
        t_job j;
        j = '0;
        j.op = op;
        jobs.push_back(j);
    endtask

    function automatic int any_coord();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    function automatic int jitter(input int c, input int spread);
        int v;
        v = c + int'($urandom_range(2 * spread)) - spread;
        if (v < -32768) v = -32768;
        if (v > 32767) v = 32767;
        return v;
    endfunction

    // ids weighted toward small values and the edges of the search range
    function automatic int pick_uid();
        int k, v;
        k = $urandom_range(9);
        if (k <= 3)
            v = $urandom_range(40);
        else if (k <= 5)
            v = gen_lo + int'($urandom_range(6)) - 3;
        else if (k == 6)
            v = gen_lim + int'($urandom_range(6)) - 3;
        else if (k == 7)
            v = 0;
        else
            v = $urandom_range(32767);
        if (v < 0) v = 0;
        if (v > 32767) v = 32767;
        return v;
    endfunction

    task automatic add_model(input int spread);
        int n_mesh, n_vert, uid, x, y, z;
        bit last_v, last_m;
        n_mesh = $urandom_range(1, 4);
        for (int m = 0; m < n_mesh; m++) begin
            uid = pick_uid();
            n_vert = ($urandom_range(7) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
            for (int k = 0; k < n_vert; k++) begin
                last_v = (k == n_vert - 1);
                last_m = last_v && (m == n_mesh - 1);
                if ($urandom_range(9) == 0) begin
                    x = any_coord();
                    y = any_coord();
                    z = any_coord();
                end else begin
                    x = jitter(gen_q[0], spread);
                    y = jitter(gen_q[1], spread);
                    z = jitter(gen_q[2], spread);
                end
                // closing vertex sometimes carries another id
                if (last_v && $urandom_range(7) == 0) uid = pick_uid();
                push_vertex(x, y, z, uid, last_v && !(last_m && $urandom_range(2) == 0),
                            last_m);
            end
        end
    endtask

    task automatic add_noise();
        int n;
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++)
            push_vertex(any_coord(), any_coord(), any_coord(), $urandom_range(32767),
                        $urandom_range(3) == 0, $urandom_range(7) == 0);
    endtask

    initial begin
        int target, waited;

        // extremes on every axis; id taken from the closing vertex
        push_vertex(-32768, -32768, -32768, 7, 0, 0);
        push_vertex(32767, 32767, 32767, 32767, 1, 0);
        // odd negative sums, center rounds toward zero
        push_vertex(-3, 5, -1, 3, 0, 0);
        push_vertex(0, 2, -4, 3, 1, 0);
        // model end without a mesh close mark still closes the mesh
        push_vertex(10, 10, 10, 9, 0, 1);
        // hit on id zero, a later match in the same model does not replace it
        push_vertex(-1, -9, -1, 0, 0, 0);
        push_vertex(1, 9, 1, 0, 1, 0);
        push_vertex(-5, 0, -5, 12, 0, 0);
        push_vertex(5, 0, 5, 12, 1, 1);
        // box edge equal to the query point is not a hit
        push_vertex(0, 3, -2, 4, 0, 0);
        push_vertex(3, -3, 2, 4, 1, 0);
        // unmarked vertex in the middle, flat box in Z
        push_vertex(-2, 0, 0, 6, 0, 0);
        push_vertex(2, 0, 0, 6, 0, 0);
        push_vertex(1, 1, 0, 6, 1, 1);
        push_vertex(-1, -1, -1, 21845, 1, 0);
        push_vertex(21845, -21846, 10922, 10922, 1, 1);

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: set_phase(100, -200, -50, 10, 20000);
                1: set_phase(-32768, 32767, 32767, 0, 131071);
                2: set_phase(any_coord(), any_coord(), any_coord(), 131071, 0);
                3: set_phase(32767, -32768, -32768, 500, 500);
                4: set_phase(any_coord(), any_coord(), any_coord(), $urandom_range(200),
                             100000);
                default: set_phase(jitter(0, 1000), jitter(0, 1000), jitter(0, 1000), 0,
                                   131071);
            endcase
            if (p == 0) begin
                // output held off while single-vertex meshes keep coming
                push_op(OP_HOLD);
                for (int k = 0; k < 30; k++)
                    push_vertex(jitter(gen_q[0], 50), any_coord(), jitter(gen_q[2], 50),
                                pick_uid(), 1, k == 29);
            end
            target = n_queued + 130;
            while (n_queued < target) begin
                if ($urandom_range(9) == 0) add_noise();
                add_model(300);
                if (p == 3 && n_queued >= target - 70 && n_queued < target - 55)
                    push_op(OP_DRAIN);
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (jobs.size() != 0 || s_valid) @(posedge i_clk);
        waited = 0;
        while (boxes_due.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        if (boxes_due.size() != 0) begin
            $display("%0d expected boxes never arrived", boxes_due.size());
            faults += boxes_due.size();
        end
        $display("Covered %0d vertices over %0d register writes: %0d boxes checked,",
                 n_taken, n_writes, n_boxes);
        $display("%0d of them carrying a hit, %0d model ends; %0d mismatches.",
                 n_hits, n_models, faults);
        if (faults == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout with %0d jobs and %0d boxes pending", jobs.size(), boxes_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
